>>> hw/rtl/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types and constants for the 8085 subset executor.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 2 ** ADDR_BITS;

  localparam logic [1:0] OPER_EXEC  = 2'd0;
  localparam logic [1:0] OPER_WRITE = 2'd1;
  localparam logic [1:0] OPER_READ  = 2'd2;

  localparam logic [7:0] OP_MVI_B  = 8'h06;
  localparam logic [7:0] OP_MVI_C  = 8'h0E;
  localparam logic [7:0] OP_MVI_D  = 8'h16;
  localparam logic [7:0] OP_MVI_E  = 8'h1E;
  localparam logic [7:0] OP_MVI_H  = 8'h26;
  localparam logic [7:0] OP_MVI_L  = 8'h2E;
  localparam logic [7:0] OP_MVI_A  = 8'h3E;
  localparam logic [7:0] OP_STAX_B = 8'h02;
  localparam logic [7:0] OP_STAX_D = 8'h12;
  localparam logic [7:0] OP_LDAX_B = 8'h0A;
  localparam logic [7:0] OP_LDAX_D = 8'h1A;
  localparam logic [7:0] OP_XCHG   = 8'hEB;
  localparam logic [7:0] OP_PCHL   = 8'hE9;
  localparam logic [7:0] OP_ADI    = 8'hC6;
  localparam logic [7:0] OP_ACI    = 8'hCE;
  localparam logic [7:0] OP_ANI    = 8'hE6;
  localparam logic [7:0] OP_HLT    = 8'h76;
  localparam logic [7:0] OP_ADD_LO = 8'h80;
  localparam logic [7:0] OP_ADD_HI = 8'h87;
  localparam logic [7:0] OP_ADC_LO = 8'h88;
  localparam logic [7:0] OP_ADC_HI = 8'h8F;
  localparam logic [7:0] OP_ANA_LO = 8'hA0;
  localparam logic [7:0] OP_ANA_HI = 8'hA7;

  localparam logic [2:0] SRC_B   = 3'd0;
  localparam logic [2:0] SRC_C   = 3'd1;
  localparam logic [2:0] SRC_D   = 3'd2;
  localparam logic [2:0] SRC_E   = 3'd3;
  localparam logic [2:0] SRC_H   = 3'd4;
  localparam logic [2:0] SRC_L   = 3'd5;
  localparam logic [2:0] SRC_MEM = 3'd6;

  typedef enum logic [1:0] {
    KIND_EXEC,
    KIND_WRITE,
    KIND_READ,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [7:0]  flag_bits;
    logic [15:0] prog_counter;
    logic        halted;
    logic        bad_opcode;
    logic [7:0]  read_data;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

endpackage

>>> hw/rtl/c8x_ram.sv
// ----------------------------------------------------------------------------
// c8x_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/c8x_front.sv
// ----------------------------------------------------------------------------
// c8x_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module c8x_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  c8x_pkg::in_item_t  in_item,
  input  logic               hold,
  output logic               req_valid,
  output c8x_pkg::req_t      req,
  input  logic               req_take
);
  import c8x_pkg::*;

  req_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       pop_ok;
  req_t       cls;

  always_comb begin
    cls.address = in_item.address;
    cls.data    = in_item.data;
    unique case (in_item.operation)
      OPER_EXEC:  cls.kind = KIND_EXEC;
      OPER_WRITE: cls.kind = KIND_WRITE;
      OPER_READ:  cls.kind = KIND_READ;
      default:    cls.kind = KIND_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2) || hold;
  assign push_ok   = in_push && !in_full;
  assign req_valid = (cnt_r != 2'd0);
  assign pop_ok    = req_take && req_valid;
  assign req       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    cnt_nxt    = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/c8x_back.sv
// ----------------------------------------------------------------------------
// c8x_back
// Carries out requests against the register file and the byte memory.
// ----------------------------------------------------------------------------
module c8x_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  c8x_pkg::req_t       req,
  output logic                req_take,
  input  logic                res_room,
  output logic                res_push,
  output c8x_pkg::out_item_t  res,
  output logic                clearing
);
  import c8x_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_RDWAIT = 6'b000100,
    ST_OPC    = 6'b001000,
    ST_IMM    = 6'b010000,
    ST_OPND   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_r, clr_nxt;
  logic [7:0]  acc_r, acc_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [7:0]  e_r, e_nxt, h_r, h_nxt, l_r, l_nxt, flags_r, flags_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic        halt_r, halt_nxt;
  logic [7:0]  op_r, op_nxt;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;

  logic [7:0]  opc, reg_src, operand, alu_res, alu_flags, rd_data;
  logic        carry_in, is_and, alu_wr, bad;
  logic [8:0]  sum9;
  logic [4:0]  half5;
  logic [15:0] pair_bc, pair_de, pair_hl;

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign pair_bc  = {b_r, c_r};
  assign pair_de  = {d_r, e_r};
  assign pair_hl  = {h_r, l_r};
  assign clearing = (state_r == ST_CLEAR);
  assign opc      = (state_r == ST_OPC) ? ram_rdata : op_r;

  always_comb begin
    case (opc[2:0])
      SRC_B:   reg_src = b_r;
      SRC_C:   reg_src = c_r;
      SRC_D:   reg_src = d_r;
      SRC_E:   reg_src = e_r;
      SRC_H:   reg_src = h_r;
      SRC_L:   reg_src = l_r;
      SRC_MEM: reg_src = ram_rdata;
      default: reg_src = acc_r;
    endcase
  end

  assign operand  = (state_r == ST_OPC) ? reg_src : ram_rdata;
  assign carry_in = ((opc == OP_ACI) || (opc[7:3] == OP_ADC_LO[7:3])) && flags_r[0];
  assign is_and   = (opc == OP_ANI) || (opc[7:3] == OP_ANA_LO[7:3]);
  assign sum9     = {1'b0, acc_r} + {1'b0, operand} + {8'd0, carry_in};
  assign half5    = {1'b0, acc_r[3:0]} + {1'b0, operand[3:0]} + {4'd0, carry_in};

  always_comb begin
    alu_res   = is_and ? (acc_r & operand) : sum9[7:0];
    alu_flags = 8'd0;
    alu_flags[7] = alu_res[7];
    alu_flags[6] = (alu_res == 8'd0);
    alu_flags[2] = ~(^alu_res);
    alu_flags[4] = is_and ? 1'b1 : half5[4];
    alu_flags[0] = is_and ? 1'b0 : sum9[8];
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    h_nxt     = h_r;
    l_nxt     = l_r;
    flags_nxt = flags_r;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    op_nxt    = op_r;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = 8'd0;
    req_take  = 1'b0;
    res_push  = 1'b0;
    alu_wr    = 1'b0;
    bad       = 1'b0;
    rd_data   = 8'd0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid && res_room) begin
          req_take = 1'b1;
          case (req.kind)
            KIND_WRITE: begin
              ram_we    = 1'b1;
              ram_addr  = req.address[ADDR_BITS-1:0];
              ram_wdata = req.data;
              res_push  = 1'b1;
            end
            KIND_READ: begin
              ram_addr  = req.address[ADDR_BITS-1:0];
              state_nxt = ST_RDWAIT;
            end
            KIND_EXEC: begin
              if (halt_r) begin
                res_push = 1'b1;
              end else begin
                ram_addr  = pc_r[ADDR_BITS-1:0];
                pc_nxt    = pc_r + 16'd1;
                state_nxt = ST_OPC;
              end
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      ST_RDWAIT: begin
        rd_data   = ram_rdata;
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_OPC: begin
        op_nxt    = ram_rdata;
        state_nxt = ST_IDLE;
        case (ram_rdata) inside
          OP_MVI_B, OP_MVI_C, OP_MVI_D, OP_MVI_E, OP_MVI_H, OP_MVI_L, OP_MVI_A,
          OP_ADI, OP_ACI, OP_ANI: begin
            ram_addr  = pc_r[ADDR_BITS-1:0];
            pc_nxt    = pc_r + 16'd1;
            state_nxt = ST_IMM;
          end
          OP_STAX_B, OP_STAX_D: begin
            ram_we    = 1'b1;
            ram_addr  = (ram_rdata == OP_STAX_B) ? pair_bc[ADDR_BITS-1:0]
                                                 : pair_de[ADDR_BITS-1:0];
            ram_wdata = acc_r;
            res_push  = 1'b1;
          end
          OP_LDAX_B, OP_LDAX_D: begin
            ram_addr  = (ram_rdata == OP_LDAX_B) ? pair_bc[ADDR_BITS-1:0]
                                                 : pair_de[ADDR_BITS-1:0];
            state_nxt = ST_OPND;
          end
          OP_XCHG: begin
            h_nxt    = d_r;
            l_nxt    = e_r;
            d_nxt    = h_r;
            e_nxt    = l_r;
            res_push = 1'b1;
          end
          OP_PCHL: begin
            pc_nxt   = pair_hl;
            res_push = 1'b1;
          end
          OP_HLT: begin
            halt_nxt = 1'b1;
            res_push = 1'b1;
          end
          [OP_ADD_LO:OP_ADD_HI], [OP_ADC_LO:OP_ADC_HI], [OP_ANA_LO:OP_ANA_HI]: begin
            if (ram_rdata[2:0] == SRC_MEM) begin
              ram_addr  = pair_hl[ADDR_BITS-1:0];
              state_nxt = ST_OPND;
            end else begin
              alu_wr   = 1'b1;
              res_push = 1'b1;
            end
          end
          default: begin
            bad      = 1'b1;
            res_push = 1'b1;
          end
        endcase
      end
      ST_IMM, ST_OPND: begin
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
        if (op_r[7:6] == 2'b00 && op_r[2:0] == SRC_MEM) begin
          case (op_r[5:3])
            SRC_B:   b_nxt   = ram_rdata;
            SRC_C:   c_nxt   = ram_rdata;
            SRC_D:   d_nxt   = ram_rdata;
            SRC_E:   e_nxt   = ram_rdata;
            SRC_H:   h_nxt   = ram_rdata;
            SRC_L:   l_nxt   = ram_rdata;
            default: acc_nxt = ram_rdata;
          endcase
        end else if (op_r == OP_LDAX_B || op_r == OP_LDAX_D) begin
          acc_nxt = ram_rdata;
        end else begin
          alu_wr = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (alu_wr) begin
      acc_nxt   = alu_res;
      flags_nxt = alu_flags;
    end
  end

  always_comb begin
    res.acc          = acc_nxt;
    res.reg_b        = b_nxt;
    res.reg_c        = c_nxt;
    res.reg_d        = d_nxt;
    res.reg_e        = e_nxt;
    res.reg_h        = h_nxt;
    res.reg_l        = l_nxt;
    res.flag_bits    = flags_nxt;
    res.prog_counter = pc_nxt;
    res.halted       = halt_nxt;
    res.bad_opcode   = bad;
    res.read_data    = rd_data;
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      acc_r   <= 8'd0;
      b_r     <= 8'd0;
      c_r     <= 8'd0;
      d_r     <= 8'd0;
      e_r     <= 8'd0;
      h_r     <= 8'd0;
      l_r     <= 8'd0;
      flags_r <= 8'd0;
      pc_r    <= 16'd0;
      halt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      acc_r   <= acc_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
      d_r     <= d_nxt;
      e_r     <= e_nxt;
      h_r     <= h_nxt;
      l_r     <= l_nxt;
      flags_r <= flags_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

>>> hw/rtl/c8x_outq.sv
// ----------------------------------------------------------------------------
// c8x_outq
// Two-entry result queue between the execution unit and the receiver.
// ----------------------------------------------------------------------------
module c8x_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  c8x_pkg::out_item_t  res,
  output logic                res_room,
  output logic                out_empty,
  input  logic                out_pop,
  output c8x_pkg::out_item_t  out_item
);
  import c8x_pkg::*;

  out_item_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       pop_ok;

  assign res_room  = (cnt_r != 2'd2);
  assign push_ok   = res_push && res_room;
  assign out_empty = (cnt_r == 2'd0);
  assign pop_ok    = out_pop && !out_empty;
  assign out_item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    cnt_nxt    = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/cpu8bit_subset_executor.sv
// ----------------------------------------------------------------------------
// cpu8bit_subset_executor
// Executes a subset of the 8085 instruction set out of an internal memory.
//
// Requests enter through a queue interface (in_push, in_full) and each one
// yields exactly one result on a second queue interface (out_empty, out_pop),
// in request order. A request writes a memory byte, reads one, or executes
// the instruction at the program counter.
// The memory is single-port: a write or an operation that does nothing
// completes in the idle state, a read adds a wait for the registered read
// data, an instruction fetches its opcode and then an immediate or operand
// byte where needed. A request is taken only once the last one is done. A
// result is queued at the earliest in the cycle after acceptance.
// After reset the memory is swept to zero, one byte a cycle, over 65536
// bytes; in_full stays high during the sweep. Two requests and two results
// can be buffered; when the receiver stalls, execution stops once the result
// queue is full and in_full rises when the request queue fills.
// ----------------------------------------------------------------------------
module cpu8bit_subset_executor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  c8x_pkg::in_item_t   in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output c8x_pkg::out_item_t  out_item
);
  import c8x_pkg::*;

  logic      req_valid;
  req_t      req;
  logic      req_take;
  logic      res_room;
  logic      res_push;
  out_item_t res;
  logic      clearing;

  c8x_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .hold      (clearing),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take)
  );

  c8x_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .res_room  (res_room),
    .res_push  (res_push),
    .res       (res),
    .clearing  (clearing)
  );

  c8x_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_room  (res_room),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

>>> sim/cpu8bit_subset_executor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8bit_subset_executor_checker
// Watches both queue interfaces of the 8085 subset executor, predicts the
// processor state after every accepted request and compares each result in
// order, field by field. The number of failures is handed to the top.
// ----------------------------------------------------------------------------
module cpu8bit_subset_executor_checker
  import c8x_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_empty,
  input  logic      out_pop,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  logic [7:0]  acc_q;
  logic [7:0]  regs_q [6];
  logic [7:0]  flags_q;
  logic [15:0] pc_q;
  logic        halt_q;
  logic [7:0]  mem_q [MEM_DEPTH];
  out_item_t   expected_states [$];

  assign pending = expected_states.size();

  function automatic logic [7:0] fetch_byte();
    logic [7:0] v;
    v = mem_q[pc_q];
    pc_q = pc_q + 16'd1;
    return v;
  endfunction

  function automatic logic [7:0] sign_zero_parity(logic [7:0] r);
    return {r[7], r == 8'd0, 3'b000, ~^r, 2'b00};
  endfunction

  function automatic void add_into_acc(logic [7:0] v, logic with_carry);
    logic [8:0] sum;
    logic [4:0] nib;
    logic       c;
    c = with_carry & flags_q[0];
    sum = acc_q + v + c;
    nib = acc_q[3:0] + v[3:0] + c;
    acc_q = sum[7:0];
    flags_q = sign_zero_parity(sum[7:0]) | {3'b000, nib[4], 3'b000, sum[8]};
  endfunction

  function automatic void and_into_acc(logic [7:0] v);
    acc_q = acc_q & v;
    flags_q = sign_zero_parity(acc_q) | 8'h10;
  endfunction

  function automatic logic [7:0] source_value(logic [2:0] sel);
    if (sel == SRC_MEM) return mem_q[{regs_q[4], regs_q[5]}];
    if (sel == 3'd7) return acc_q;
    return regs_q[sel];
  endfunction

  function automatic logic execute_instruction();
    logic [7:0] op;
    logic [7:0] t;
    op = fetch_byte();
    case (op)
      OP_MVI_A: acc_q = fetch_byte();
      OP_MVI_B: regs_q[0] = fetch_byte();
      OP_MVI_C: regs_q[1] = fetch_byte();
      OP_MVI_D: regs_q[2] = fetch_byte();
      OP_MVI_E: regs_q[3] = fetch_byte();
      OP_MVI_H: regs_q[4] = fetch_byte();
      OP_MVI_L: regs_q[5] = fetch_byte();
      OP_STAX_B: mem_q[{regs_q[0], regs_q[1]}] = acc_q;
      OP_STAX_D: mem_q[{regs_q[2], regs_q[3]}] = acc_q;
      OP_LDAX_B: acc_q = mem_q[{regs_q[0], regs_q[1]}];
      OP_LDAX_D: acc_q = mem_q[{regs_q[2], regs_q[3]}];
      OP_XCHG: begin
        t = regs_q[4]; regs_q[4] = regs_q[2]; regs_q[2] = t;
        t = regs_q[5]; regs_q[5] = regs_q[3]; regs_q[3] = t;
      end
      OP_PCHL: pc_q = {regs_q[4], regs_q[5]};
      OP_ADI: add_into_acc(fetch_byte(), 1'b0);
      OP_ACI: add_into_acc(fetch_byte(), 1'b1);
      OP_ANI: and_into_acc(fetch_byte());
      OP_HLT: halt_q = 1'b1;
      default: begin
        if (op >= OP_ADD_LO && op <= OP_ADD_HI) add_into_acc(source_value(op[2:0]), 1'b0);
        else if (op >= OP_ADC_LO && op <= OP_ADC_HI) add_into_acc(source_value(op[2:0]), 1'b1);
        else if (op >= OP_ANA_LO && op <= OP_ANA_HI) and_into_acc(source_value(op[2:0]));
        else return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic out_item_t apply_request(in_item_t req);
    out_item_t r;
    logic bad;
    logic [7:0] rd;
    bad = 1'b0;
    rd = 8'd0;
    case (req.operation)
      OPER_EXEC: if (!halt_q) bad = execute_instruction();
      OPER_WRITE: mem_q[req.address] = req.data;
      OPER_READ: rd = mem_q[req.address];
      default: ;
    endcase
    r.acc = acc_q;
    r.reg_b = regs_q[0];
    r.reg_c = regs_q[1];
    r.reg_d = regs_q[2];
    r.reg_e = regs_q[3];
    r.reg_h = regs_q[4];
    r.reg_l = regs_q[5];
    r.flag_bits = flags_q;
    r.prog_counter = pc_q;
    r.halted = halt_q;
    r.bad_opcode = bad;
    r.read_data = rd;
    return r;
  endfunction

  task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      acc_q <= '0;
      flags_q <= '0;
      pc_q <= '0;
      halt_q <= 1'b0;
      fail_count <= 0;
      foreach (regs_q[i]) regs_q[i] <= '0;
      foreach (mem_q[i]) mem_q[i] = '0;
      expected_states.delete();
    end else begin
      if (in_push && !in_full) expected_states.push_back(apply_request(in_item));
      if (out_pop && !out_empty) begin
        if (expected_states.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_states.pop_front();
          compare_field("acc", e.acc, out_item.acc);
          compare_field("reg_b", e.reg_b, out_item.reg_b);
          compare_field("reg_c", e.reg_c, out_item.reg_c);
          compare_field("reg_d", e.reg_d, out_item.reg_d);
          compare_field("reg_e", e.reg_e, out_item.reg_e);
          compare_field("reg_h", e.reg_h, out_item.reg_h);
          compare_field("reg_l", e.reg_l, out_item.reg_l);
          compare_field("flag_bits", e.flag_bits, out_item.flag_bits);
          compare_field("prog_counter", e.prog_counter, out_item.prog_counter);
          compare_field("halted", e.halted, out_item.halted);
          compare_field("bad_opcode", e.bad_opcode, out_item.bad_opcode);
          compare_field("read_data", e.read_data, out_item.read_data);
        end
      end
    end
  end

endmodule

>>> sim/tb_cpu8bit_subset_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu8bit_subset_executor
// Loads short programs into the executor's memory, runs them one instruction
// per request and reads memory back, with random stalls on both interfaces.
// ----------------------------------------------------------------------------
module tb_cpu8bit_subset_executor;
  import c8x_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  logic      hold_results;
  logic      stimulus_done;
  int        idle_cycles;
  logic [15:0] prog_ptr;

  cpu8bit_subset_executor dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  cpu8bit_subset_executor_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_request(logic [1:0] oper, logic [15:0] addr, logic [7:0] dat);
    int gap;
    gap = gap_length();
    repeat (gap) @(negedge clk);
    in_item = '{operation: oper, address: addr, data: dat};
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic store_byte(logic [15:0] addr, logic [7:0] dat);
    send_request(OPER_WRITE, addr, dat);
  endtask

  task automatic step_cpu();
    send_request(OPER_EXEC, 16'($urandom()), 8'($urandom()));
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_opcode();
    logic [7:0] table_ops [17];
    table_ops = '{OP_MVI_A, OP_MVI_B, OP_MVI_C, OP_MVI_D, OP_MVI_E, OP_MVI_H, OP_MVI_L,
                  OP_STAX_B, OP_STAX_D, OP_LDAX_B, OP_LDAX_D, OP_XCHG, OP_ADI, OP_ACI,
                  OP_ANI, OP_PCHL, OP_HLT};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return table_ops[$urandom_range(0, 14)];
      4: return 8'(OP_ADD_LO + $urandom_range(0, 7));
      5: return 8'(OP_ADC_LO + $urandom_range(0, 7));
      6: return 8'(OP_ANA_LO + $urandom_range(0, 7));
      7: return ($urandom_range(0, 3) == 0) ? OP_PCHL : OP_MVI_H;
      8: return ($urandom_range(0, 5) == 0) ? OP_HLT : OP_ADI;
      default: return 8'($urandom());
    endcase
  endfunction

  // Writes a program of random instructions at the counter and executes it.
  task automatic run_program(int count);
    logic [7:0] op;
    for (int i = 0; i < count; i++) begin
      op = random_opcode();
      store_byte(prog_ptr, op);
      store_byte(prog_ptr + 16'd1, 8'($urandom()));
      step_cpu();
      prog_ptr = checker_i.pc_q;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("cpu8bit_subset_executor: mismatch");
      $finish;
    end
  end

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) out_pop <= 1'b0;
      else if ($urandom_range(0, 19) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(5, 30)) @(negedge clk);
      end else out_pop <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    hold_results = 1'b0;
    stimulus_done = 1'b0;
    prog_ptr = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: memory extremes, flag corners, an unused operation code and a bad opcode.
    store_byte(16'h0000, OP_MVI_A);   store_byte(16'h0001, 8'hFF);
    store_byte(16'h0002, OP_ADI);     store_byte(16'h0003, 8'h01);
    store_byte(16'h0004, OP_ACI);     store_byte(16'h0005, 8'h0F);
    store_byte(16'h0006, OP_ANI);     store_byte(16'h0007, 8'h00);
    store_byte(16'hFFFF, 8'hA5);
    send_request(OPER_READ, 16'hFFFF, 8'h00);
    send_request(2'd3, 16'h1234, 8'hFF);
    repeat (4) step_cpu();
    prog_ptr = checker_i.pc_q;
    store_byte(prog_ptr, 8'hFF);
    step_cpu();
    wait_drained();

    // Counter wrap through PCHL to the top of memory.
    store_byte(16'h0009, OP_MVI_H);  store_byte(16'h000A, 8'hFF);
    store_byte(16'h000B, OP_MVI_L);  store_byte(16'h000C, 8'hFF);
    store_byte(16'h000D, OP_PCHL);
    store_byte(16'hFFFF, OP_XCHG);
    repeat (4) step_cpu();
    prog_ptr = checker_i.pc_q;

    run_program(40);

    // Long receiver hold so the result queue fills and in_full rises.
    wait_drained();
    hold_results = 1'b1;
    fork
      begin
        repeat (150) @(negedge clk);
        hold_results = 1'b0;
      end
      run_program(6);
    join
    wait_drained();

    for (int k = 0; k < 28; k++) begin
      if (checker_i.halt_q) begin
        send_request(OPER_READ, 16'($urandom()), 8'h00);
        step_cpu();
      end
      run_program(3);
      if ($urandom_range(0, 3) == 0)
        send_request(OPER_READ, {checker_i.regs_q[4], checker_i.regs_q[5]}, 8'h00);
      if ($urandom_range(0, 5) == 0)
        send_request(2'($urandom_range(1, 3)), 16'($urandom()), 8'($urandom()));
    end

    stimulus_done = 1'b1;
    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("cpu8bit_subset_executor: match");
    else $display("cpu8bit_subset_executor: mismatch");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/c8x_pkg.sv
hw/rtl/c8x_ram.sv
hw/rtl/c8x_front.sv
hw/rtl/c8x_back.sv
hw/rtl/c8x_outq.sv
hw/rtl/cpu8bit_subset_executor.sv
sim/cpu8bit_subset_executor_checker.sv
sim/tb_cpu8bit_subset_executor.sv
